@@ src/assert_macros.svh @@
// assertion macros used by the checker file
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising edge while reset is low
`define KMM_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("kmm assertion failed");

// property checked on every rising edge, reset included
`define KMM_ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("kmm assertion failed");

`endif

@@ src/kmm_pkg.sv @@
// package for the keyed min/max tracker: widths, codes, types
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package kmm_pkg;

   localparam int DEFAULT_ENTRIES = 64;
   localparam int REQ_W = 2;
   localparam int KIND_W = 2;
   localparam int STAT_W = 2;
   localparam int KEY_W = 32;
   localparam int VAL_W = 64;
   localparam int WORD_W = KEY_W + 2 * VAL_W;

   // request codes
   localparam logic [REQ_W-1:0] REQ_MODIFY = 2'd0;
   localparam logic [REQ_W-1:0] REQ_COMMIT = 2'd1;
   localparam logic [REQ_W-1:0] REQ_ABORT = 2'd2;

   // result kinds
   localparam logic [KIND_W-1:0] KIND_MODIFY = 2'd0;
   localparam logic [KIND_W-1:0] KIND_FLUSH = 2'd1;
   localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd2;

   // modify status
   localparam logic [STAT_W-1:0] STAT_UPDATED = 2'd0;
   localparam logic [STAT_W-1:0] STAT_CREATED = 2'd1;
   localparam logic [STAT_W-1:0] STAT_FULL = 2'd2;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_FLUSH
   } state_type;

   // lookup outcome from the key match unit
   typedef struct packed {
      logic hit;
      logic full;
      logic empty;
   } match_stat_type;

   // slot table update from the controller
   typedef struct packed {
      logic set;
      logic clear;
   } slot_upd_type;

endpackage

`default_nettype wire

@@ src/kmm_ram.sv @@
// generic single write, single read ram with registered read data
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

module kmm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                                  clock,
   input  wire logic                                  wr_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                      wr_data,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                           rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

@@ src/kmm_match.sv @@
// key match unit: slot used bits, key registers, parallel compare, slot select
// depends on kmm_pkg
`timescale 1ns / 1ps
`default_nettype none

module kmm_match #(
   parameter int ENTRIES = kmm_pkg::DEFAULT_ENTRIES
) (
   input  wire logic                                       clock,
   input  wire logic                                       reset,
   input  wire logic [kmm_pkg::KEY_W-1:0]                  lookup_key,
   output kmm_pkg::match_stat_type                         match_stat,
   output logic [((ENTRIES > 1) ? $clog2(ENTRIES) : 1)-1:0] match_idx,
   output logic [ENTRIES-1:0]                              used_vec,
   input  kmm_pkg::slot_upd_type                           upd,
   input  wire logic [((ENTRIES > 1) ? $clog2(ENTRIES) : 1)-1:0] upd_idx,
   input  wire logic [kmm_pkg::KEY_W-1:0]                  upd_key
);

   import kmm_pkg::*;

   localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

   logic [ENTRIES-1:0] used_ff;
   logic [ENTRIES-1:0] used_in;
   logic [KEY_W-1:0]   key_ff [ENTRIES];
   logic [ENTRIES-1:0] hit_vec;
   logic [IDX_W-1:0]   hit_idx;
   logic [IDX_W-1:0]   free_idx;

   always_comb begin
      for (int i = 0; i < ENTRIES; i++) begin
         hit_vec[i] = used_ff[i] && (key_ff[i] == lookup_key);
      end
   end

   // lowest hit and lowest free slot
   always_comb begin
      hit_idx = '0;
      free_idx = '0;
      for (int i = ENTRIES - 1; i >= 0; i--) begin
         if (hit_vec[i]) begin
            hit_idx = IDX_W'(i);
         end
         if (!used_ff[i]) begin
            free_idx = IDX_W'(i);
         end
      end
   end

   always_comb begin
      match_stat.hit = |hit_vec;
      match_stat.full = &used_ff;
      match_stat.empty = ~|used_ff;
      match_idx = match_stat.hit ? hit_idx : free_idx;
   end

   always_comb begin
      used_in = used_ff;
      if (upd.clear) begin
         used_in = '0;
      end else if (upd.set) begin
         used_in[upd_idx] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff <= '0;
      end else begin
         used_ff <= used_in;
      end
   end

   always_ff @(posedge clock) begin
      if (upd.set) begin
         key_ff[upd_idx] <= upd_key;
      end
   end

   assign used_vec = used_ff;

endmodule

`default_nettype wire

@@ src/keyed_min_max_tracker.sv @@
// top level of the keyed min/max tracker: controller, bound update, flush walk
// depends on kmm_pkg, kmm_match, kmm_ram
`timescale 1ns / 1ps
`default_nettype none

// Usage
//   Request channel: a request is taken at a rising edge with start high and
//   busy low. req_type selects modify, commit or abort; type three is taken
//   and ignored.
//   Response channel: each result is shown for one cycle with rsp_valid high;
//   the receiver cannot stall, so every result must be taken as it appears.
//   Modify: keys are matched against all slots in the request cycle and the
//   slot's bounds are read from the bound ram; the next cycle updates and
//   writes back. One result follows, registered from the update; busy is
//   high during the update, so the next modify is taken once it is done.
//   Abort, and commit on an empty table: one result in the next cycle, busy
//   stays low, so such a request can follow every cycle.
//   Commit: the walk reads one used slot per cycle from the ram, results
//   stream one per cycle through the ram read and response registers; the
//   block stays busy until the walk is done, then the table is empty.
//   Reset clears the used bits and the controller; no clearing pass is needed.

module keyed_min_max_tracker #(
   parameter int ENTRIES = kmm_pkg::DEFAULT_ENTRIES
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   output logic                               busy,
   input  wire logic [kmm_pkg::REQ_W-1:0]     req_type,
   input  wire logic [kmm_pkg::KEY_W-1:0]     req_table_key,
   input  wire logic signed [kmm_pkg::VAL_W-1:0] req_sample_value,
   output logic                               rsp_valid,
   output logic [kmm_pkg::KIND_W-1:0]         rsp_result_kind,
   output logic [kmm_pkg::KEY_W-1:0]          rsp_entry_key,
   output logic signed [kmm_pkg::VAL_W-1:0]   rsp_lowest_seen,
   output logic signed [kmm_pkg::VAL_W-1:0]   rsp_greatest_seen,
   output logic [kmm_pkg::STAT_W-1:0]         rsp_status,
   output logic                               rsp_entry_valid,
   output logic                               rsp_last_result
);

   import kmm_pkg::*;

   localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

   state_type state_ff;
   state_type state_in;
   logic      accept;

   match_stat_type     mstat;
   logic [IDX_W-1:0]   midx;
   logic [ENTRIES-1:0] used_vec;
   slot_upd_type       upd;

   // modify in flight
   logic [KEY_W-1:0]        mod_key_ff;
   logic signed [VAL_W-1:0] mod_val_ff;
   logic [IDX_W-1:0]        mod_idx_ff;
   logic                    mod_hit_ff;
   logic                    mod_full_ff;

   // flush walk
   logic [ENTRIES-1:0] pend_ff;
   logic [ENTRIES-1:0] pend_in;
   logic [ENTRIES-1:0] pend_rest;
   logic [IDX_W-1:0]   pend_idx;
   logic               frd_ff;
   logic               frd_in;
   logic               flast_ff;
   logic               flast_in;

   // bound ram
   logic              wr_en;
   logic [WORD_W-1:0] wr_data;
   logic [IDX_W-1:0]  rd_addr;
   logic [WORD_W-1:0] rd_data;
   logic [KEY_W-1:0]        rd_key;
   logic signed [VAL_W-1:0] rd_lo;
   logic signed [VAL_W-1:0] rd_hi;

   logic signed [VAL_W-1:0] base_lo;
   logic signed [VAL_W-1:0] base_hi;
   logic signed [VAL_W-1:0] new_lo;
   logic signed [VAL_W-1:0] new_hi;
   logic                    below_lo;

   // response registers
   logic                    rsp_valid_ff;
   logic                    rsp_valid_in;
   logic [KIND_W-1:0]       rsp_kind_ff;
   logic [KIND_W-1:0]       rsp_kind_in;
   logic [KEY_W-1:0]        rsp_key_ff;
   logic [KEY_W-1:0]        rsp_key_in;
   logic signed [VAL_W-1:0] rsp_lo_ff;
   logic signed [VAL_W-1:0] rsp_lo_in;
   logic signed [VAL_W-1:0] rsp_hi_ff;
   logic signed [VAL_W-1:0] rsp_hi_in;
   logic [STAT_W-1:0]       rsp_stat_ff;
   logic [STAT_W-1:0]       rsp_stat_in;
   logic                    rsp_ev_ff;
   logic                    rsp_ev_in;
   logic                    rsp_last_ff;
   logic                    rsp_last_in;

   assign busy = (state_ff != ST_IDLE);
   assign accept = start && (state_ff == ST_IDLE);

   kmm_match #(
      .ENTRIES (ENTRIES)
   ) u_match (
      .clock      (clock),
      .reset      (reset),
      .lookup_key (req_table_key),
      .match_stat (mstat),
      .match_idx  (midx),
      .used_vec   (used_vec),
      .upd        (upd),
      .upd_idx    (mod_idx_ff),
      .upd_key    (mod_key_ff)
   );

   kmm_ram #(
      .WIDTH (WORD_W),
      .DEPTH (ENTRIES)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (mod_idx_ff),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign rd_key = rd_data[WORD_W-1 -: KEY_W];
   assign rd_lo = rd_data[2*VAL_W-1 -: VAL_W];
   assign rd_hi = rd_data[VAL_W-1:0];

   // lowest pending slot of the flush walk
   always_comb begin
      pend_idx = '0;
      for (int i = ENTRIES - 1; i >= 0; i--) begin
         if (pend_ff[i]) begin
            pend_idx = IDX_W'(i);
         end
      end
      pend_rest = pend_ff & (pend_ff - ENTRIES'(1));
   end

   assign rd_addr = (state_ff == ST_FLUSH) ? pend_idx : midx;

   // bound update, a new slot starts from the value itself
   always_comb begin
      base_lo = mod_hit_ff ? rd_lo : mod_val_ff;
      base_hi = mod_hit_ff ? rd_hi : mod_val_ff;
      below_lo = (mod_val_ff < base_lo);
      new_lo = below_lo ? mod_val_ff : base_lo;
      new_hi = (!below_lo && (base_hi < mod_val_ff)) ? mod_val_ff : base_hi;
      wr_data = {mod_key_ff, new_lo, new_hi};
   end

   always_comb begin
      state_in = state_ff;
      upd = '0;
      wr_en = 1'b0;
      pend_in = pend_ff;
      frd_in = 1'b0;
      flast_in = flast_ff;
      rsp_valid_in = 1'b0;
      rsp_kind_in = KIND_MODIFY;
      rsp_key_in = '0;
      rsp_lo_in = '0;
      rsp_hi_in = '0;
      rsp_stat_in = STAT_UPDATED;
      rsp_ev_in = 1'b0;
      rsp_last_in = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req_type)
                  REQ_MODIFY: begin
                     state_in = ST_EXEC;
                  end
                  REQ_COMMIT: begin
                     if (mstat.empty) begin
                        rsp_valid_in = 1'b1;
                        rsp_kind_in = KIND_FLUSH;
                        rsp_last_in = 1'b1;
                     end else begin
                        pend_in = used_vec;
                        state_in = ST_FLUSH;
                     end
                  end
                  REQ_ABORT: begin
                     upd.clear = 1'b1;
                     rsp_valid_in = 1'b1;
                     rsp_kind_in = KIND_CLEAR;
                     rsp_last_in = 1'b1;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_EXEC: begin
            state_in = ST_IDLE;
            rsp_valid_in = 1'b1;
            rsp_kind_in = KIND_MODIFY;
            rsp_key_in = mod_key_ff;
            rsp_last_in = 1'b1;
            if (mod_full_ff) begin
               rsp_stat_in = STAT_FULL;
            end else begin
               wr_en = 1'b1;
               upd.set = !mod_hit_ff;
               rsp_lo_in = new_lo;
               rsp_hi_in = new_hi;
               rsp_stat_in = mod_hit_ff ? STAT_UPDATED : STAT_CREATED;
               rsp_ev_in = 1'b1;
            end
         end
         ST_FLUSH: begin
            if (frd_ff) begin
               rsp_valid_in = 1'b1;
               rsp_kind_in = KIND_FLUSH;
               rsp_key_in = rd_key;
               rsp_lo_in = rd_lo;
               rsp_hi_in = rd_hi;
               rsp_ev_in = 1'b1;
               rsp_last_in = flast_ff;
            end
            if (|pend_ff) begin
               frd_in = 1'b1;
               flast_in = ~|pend_rest;
               pend_in = pend_rest;
            end else begin
               upd.clear = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         frd_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         frd_ff <= frd_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         mod_key_ff <= req_table_key;
         mod_val_ff <= req_sample_value;
         mod_idx_ff <= midx;
         mod_hit_ff <= mstat.hit;
         mod_full_ff <= mstat.full && !mstat.hit;
      end
      pend_ff <= pend_in;
      flast_ff <= flast_in;
      rsp_kind_ff <= rsp_kind_in;
      rsp_key_ff <= rsp_key_in;
      rsp_lo_ff <= rsp_lo_in;
      rsp_hi_ff <= rsp_hi_in;
      rsp_stat_ff <= rsp_stat_in;
      rsp_ev_ff <= rsp_ev_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_result_kind = rsp_kind_ff;
   assign rsp_entry_key = rsp_key_ff;
   assign rsp_lowest_seen = rsp_lo_ff;
   assign rsp_greatest_seen = rsp_hi_ff;
   assign rsp_status = rsp_stat_ff;
   assign rsp_entry_valid = rsp_ev_ff;
   assign rsp_last_result = rsp_last_ff;

endmodule

`default_nettype wire

@@ src/kmm_checker.sv @@
// port level checks for the keyed min/max tracker, bound to the top level
// depends on kmm_pkg and assert_macros.svh
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module kmm_checker (
   input wire logic                          clock,
   input wire logic                          reset,
   input wire logic                          start,
   input wire logic                          busy,
   input wire logic [kmm_pkg::REQ_W-1:0]     req_type,
   input wire logic                          rsp_valid,
   input wire logic [kmm_pkg::KIND_W-1:0]    rsp_result_kind,
   input wire logic [kmm_pkg::STAT_W-1:0]    rsp_status,
   input wire logic                          rsp_entry_valid,
   input wire logic                          rsp_last_result
);

   import kmm_pkg::*;

   logic take_modify;
   logic take_abort;
   logic modify_rsp;
   logic clear_rsp;
   logic full_rsp;

   assign take_modify = start && !busy && (req_type == REQ_MODIFY);
   assign take_abort = start && !busy && (req_type == REQ_ABORT);
   assign modify_rsp = rsp_valid && rsp_last_result && (rsp_result_kind == KIND_MODIFY);
   assign clear_rsp = rsp_valid && (rsp_result_kind == KIND_CLEAR) && !rsp_entry_valid
      && rsp_last_result;
   assign full_rsp = rsp_valid && (rsp_status == STAT_FULL);

   // modify keeps busy high after the request, then answers with a single result
   `KMM_ASSERT(a_modify_latency, clock, reset, take_modify |=> busy ##1 modify_rsp)
   // abort answers in the next cycle with an empty clear result
   `KMM_ASSERT(a_abort_result, clock, reset, take_abort |=> (clear_rsp && !busy))
   // dropped modify carries no entry
   `KMM_ASSERT(a_full_no_entry, clock, reset, full_rsp |-> !rsp_entry_valid)
   // reset leaves the block idle and silent
   `KMM_ASSERT_ALWAYS(a_reset_idle, clock, reset |=> (!busy && !rsp_valid))

endmodule

bind keyed_min_max_tracker kmm_checker u_kmm_checker (.*);

`default_nettype wire
